>>> rtl/core/dsd_pkg.sv
package dsd_pkg;

  localparam logic [7:0] SYNC_GYRO = 8'hFE;
  localparam logic [7:0] SYNC_DATA = 8'hFF;

  localparam logic KIND_GYRO = 1'b0;
  localparam logic KIND_DATA = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [4:0]  index;
    logic [15:0] value;
    logic        last;
  } dsd_word_t;

endpackage

>>> rtl/core/dual_sync_packet_deframer_top.sv
// Bytes are held in the input register; completed words in the output register.
// Throughput: one byte per cycle; the input register and the output register
// advance together, so bytes stream without gaps while out_stall is low.
// Reset: synchronous active-low rst_n empties both registers and returns the
// header search to hunting.
module dual_sync_packet_deframer_top #(
  parameter int DATA_PACKET_BYTES = 40,
  parameter int GYRO_PACKET_BYTES = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_packet_kind,
  output logic [4:0]         out_word_index,
  output logic signed [15:0] out_word_value,
  output logic               out_last_word
);

  localparam logic [4:0] GYRO_LAST_INDEX = 5'((GYRO_PACKET_BYTES - 1) / 2);
  localparam logic [4:0] DATA_LAST_INDEX = 5'((DATA_PACKET_BYTES - 1) / 2);

  logic               byte_v_r;
  logic [7:0]         byte_r;
  logic               out_v_r;
  dsd_pkg::dsd_word_t out_r;
  logic               out_free;
  logic               go;
  logic               emit;
  dsd_pkg::dsd_word_t word;

  assign out_free = !out_v_r || !out_stall;
  assign go       = byte_v_r && out_free;
  assign in_stall = byte_v_r && !out_free;

  dsd_framer #(
    .DATA_PACKET_BYTES(DATA_PACKET_BYTES),
    .GYRO_PACKET_BYTES(GYRO_PACKET_BYTES)
  ) u_framer (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (go),
    .rx_byte(byte_r),
    .emit   (emit),
    .word   (word)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        byte_v_r <= 1'b1;
      end else if (go) begin
        byte_v_r <= 1'b0;
      end
      if (go) begin
        out_v_r <= emit;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
    if (in_valid && !in_stall) begin
      byte_r <= in_rx_byte;
    end
    if (go && emit) begin
      out_r <= word;
    end
  end

  assign out_valid       = out_v_r;
  assign out_packet_kind = out_r.kind;
  assign out_word_index  = out_r.index;
  assign out_word_value  = $signed(out_r.value);
  assign out_last_word   = out_r.last;

  a_stall_needs_byte: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> byte_v_r)
    else $error("input stalled with empty input register");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_word) |->
      (out_word_index == (out_packet_kind ? DATA_LAST_INDEX : GYRO_LAST_INDEX)))
    else $error("last word at wrong index");

  a_data_header: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_packet_kind && out_word_index == 5'd0) |->
      (out_word_value == 16'shFFFF))
    else $error("data header word mismatch");

endmodule

>>> rtl/core/dsd_framer.sv
module dsd_framer #(
  parameter int DATA_PACKET_BYTES = 40,
  parameter int GYRO_PACKET_BYTES = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  logic [7:0]         rx_byte,
  output logic               emit,
  output dsd_pkg::dsd_word_t word
);

  localparam logic [5:0] DATA_SIZE = 6'(DATA_PACKET_BYTES);
  localparam logic [5:0] GYRO_SIZE = 6'(GYRO_PACKET_BYTES);
  localparam logic DATA_HDR_LAST = (DATA_PACKET_BYTES <= 2);
  localparam logic GYRO_HDR_LAST = (GYRO_PACKET_BYTES <= 2);

  typedef enum logic [2:0] {
    ST_HUNT    = 3'd0,
    ST_SEEN_FE = 3'd1,
    ST_GYRO    = 3'd2,
    ST_SEEN_FF = 3'd3,
    ST_DATA    = 3'd4
  } state_t;

  state_t     state_r, state_nxt;
  logic [5:0] count_r, count_nxt;
  logic [7:0] held_r, held_nxt;

  logic       kind;
  logic [5:0] size;
  logic       hdr_last;
  logic [5:0] cnt;
  logic       last;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    held_nxt  = held_r;
    emit      = 1'b0;
    word      = '0;
    kind      = (state_r == ST_SEEN_FF) || (state_r == ST_DATA);
    size      = kind ? DATA_SIZE : GYRO_SIZE;
    hdr_last  = kind ? DATA_HDR_LAST : GYRO_HDR_LAST;
    cnt       = count_r + 6'd1;
    last      = (cnt >= size);
    word.kind = kind;
    case (state_r)
      ST_SEEN_FE, ST_SEEN_FF: begin
        if (rx_byte == (kind ? dsd_pkg::SYNC_DATA : dsd_pkg::SYNC_GYRO)) begin
          emit       = 1'b1;
          word.index = 5'd0;
          word.value = {held_r, rx_byte};
          word.last  = hdr_last;
          if (hdr_last) begin
            state_nxt = ST_HUNT;
            count_nxt = 6'd0;
          end else begin
            state_nxt = kind ? ST_DATA : ST_GYRO;
            count_nxt = 6'd2;
          end
        end else begin
          state_nxt = ST_HUNT;
          count_nxt = 6'd0;
        end
      end
      ST_GYRO, ST_DATA: begin
        if (last) begin
          state_nxt = ST_HUNT;
          count_nxt = 6'd0;
        end else begin
          count_nxt = cnt;
        end
        if (!cnt[0]) begin
          emit       = 1'b1;
          word.index = cnt[5:1] - 5'd1;
          word.value = {held_r, rx_byte};
          word.last  = last;
        end else begin
          held_nxt = rx_byte;
          if (last) begin
            emit       = 1'b1;
            word.index = cnt[5:1];
            word.value = {rx_byte, 8'h00};
            word.last  = 1'b1;
          end
        end
      end
      default: begin
        if (rx_byte == dsd_pkg::SYNC_GYRO) begin
          state_nxt = ST_SEEN_FE;
          count_nxt = 6'd1;
          held_nxt  = rx_byte;
        end else if (rx_byte == dsd_pkg::SYNC_DATA) begin
          state_nxt = ST_SEEN_FF;
          count_nxt = 6'd1;
          held_nxt  = rx_byte;
        end else begin
          state_nxt = ST_HUNT;
          count_nxt = 6'd0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT;
      count_r <= 6'd0;
    end else if (go) begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    if (go) begin
      held_r <= held_nxt;
    end
  end

endmodule
